// ----- rtl/prq_pkg.sv -----
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and codes of the priority ready queue: operation and status
// codes, field widths and the control and flag bundles of the cell chain.
// ----------------------------------------------------------------------------
package prq_pkg;

    // Widths fixed by the beat layout.
    localparam int TASK_W     = 5;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int PRIO_REQ_W = 8;
    localparam int COUNT_W    = 6;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_TASKS     = 32;
    localparam int DEF_PRIORITY_BITS = 8;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_QUEUED    = 2'd2;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic load_hole;  // mark the cell holding the key task as a gap
        logic compact;    // move the gap one cell toward the tail
        logic insert;     // open a slot in front of the first larger priority
    } prq_ctrl_t;

    // Summary flags gathered from the chain.
    typedef struct packed {
        logic any_match;  // the key task is queued
        logic same_prio;  // ... and already has the key priority
        logic hole_any;   // a gap is still travelling down the chain
    } prq_flags_t;

endpackage

// ----- rtl/prq_cell.sv -----
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted queue: task id, priority and valid bit, with the
// local rules for inserting from the left neighbor and closing a gap from
// the right neighbor.
// ----------------------------------------------------------------------------
module prq_cell #(
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  prq_pkg::prq_ctrl_t         ctrl,
    input  logic [prq_pkg::TASK_W-1:0] key_task,
    input  logic [PRIORITY_BITS-1:0]   key_prio,
    input  logic [prq_pkg::TASK_W-1:0] left_task,
    input  logic [PRIORITY_BITS-1:0]   left_prio,
    input  logic                       left_valid,
    input  logic                       left_gt,
    input  logic                       left_hole,
    input  logic [prq_pkg::TASK_W-1:0] right_task,
    input  logic [PRIORITY_BITS-1:0]   right_prio,
    input  logic                       right_valid,
    output logic [prq_pkg::TASK_W-1:0] cell_task,
    output logic [PRIORITY_BITS-1:0]   cell_prio,
    output logic                       cell_valid,
    output logic                       cell_hole,
    output logic                       cell_gt,
    output logic                       cell_match,
    output logic                       cell_same
);
    import prq_pkg::*;

    logic [TASK_W-1:0]        task_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic                     valid_reg;
    logic                     hole_reg;

    // An empty cell counts as larger than any priority, so the new task lands
    // behind every queued task of equal or smaller number.
    assign cell_gt    = !valid_reg || (prio_reg > key_prio);
    assign cell_match = valid_reg && (task_reg == key_task);
    assign cell_same  = cell_match && (prio_reg == key_prio);

    assign cell_task  = task_reg;
    assign cell_prio  = prio_reg;
    assign cell_valid = valid_reg;
    assign cell_hole  = hole_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hole_reg  <= 1'b0;
        end else if (ctrl.load_hole) begin
            hole_reg <= cell_match;
        end else if (ctrl.compact) begin
            if (hole_reg) begin
                // The gap either moves on or falls off the tail.
                if (!right_valid) begin
                    valid_reg <= 1'b0;
                end
                hole_reg <= 1'b0;
            end else if (left_hole && valid_reg) begin
                hole_reg <= 1'b1;
            end
        end else if (ctrl.insert && cell_gt) begin
            valid_reg <= left_gt ? left_valid : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.compact && hole_reg && right_valid) begin
            task_reg <= right_task;
            prio_reg <= right_prio;
        end else if (ctrl.insert && cell_gt) begin
            if (left_gt) begin
                task_reg <= left_task;
                prio_reg <= left_prio;
            end else begin
                task_reg <= key_task;
                prio_reg <= key_prio;
            end
        end
    end

endmodule

// ----- rtl/prq_chain.sv -----
// ----------------------------------------------------------------------------
// prq_chain
// The row of queue cells, head at cell 0, with the neighbor links and the
// summary flags that the controller reads.
// ----------------------------------------------------------------------------
module prq_chain #(
    parameter int MAX_TASKS     = prq_pkg::DEF_MAX_TASKS,
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  prq_pkg::prq_ctrl_t         ctrl,
    input  logic [prq_pkg::TASK_W-1:0] key_task,
    input  logic [PRIORITY_BITS-1:0]   key_prio,
    output logic [prq_pkg::TASK_W-1:0] head_task,
    output prq_pkg::prq_flags_t        flags
);
    import prq_pkg::*;

    logic [TASK_W-1:0]        task_q [MAX_TASKS];
    logic [PRIORITY_BITS-1:0] prio_q [MAX_TASKS];
    logic [MAX_TASKS-1:0]     valid_q;
    logic [MAX_TASKS-1:0]     hole_q;
    logic [MAX_TASKS-1:0]     gt_q;
    logic [MAX_TASKS-1:0]     match_q;
    logic [MAX_TASKS-1:0]     same_q;

    for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
        logic [TASK_W-1:0]        l_task;
        logic [PRIORITY_BITS-1:0] l_prio;
        logic                     l_valid;
        logic                     l_gt;
        logic                     l_hole;
        logic [TASK_W-1:0]        r_task;
        logic [PRIORITY_BITS-1:0] r_prio;
        logic                     r_valid;

        if (i == 0) begin : g_head
            assign l_task  = '0;
            assign l_prio  = '0;
            assign l_valid = 1'b0;
            assign l_gt    = 1'b0;
            assign l_hole  = 1'b0;
        end else begin : g_link_left
            assign l_task  = task_q[i-1];
            assign l_prio  = prio_q[i-1];
            assign l_valid = valid_q[i-1];
            assign l_gt    = gt_q[i-1];
            assign l_hole  = hole_q[i-1];
        end

        if (i == MAX_TASKS - 1) begin : g_tail
            assign r_task  = '0;
            assign r_prio  = '0;
            assign r_valid = 1'b0;
        end else begin : g_link_right
            assign r_task  = task_q[i+1];
            assign r_prio  = prio_q[i+1];
            assign r_valid = valid_q[i+1];
        end

        prq_cell #(
            .PRIORITY_BITS(PRIORITY_BITS)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .key_task   (key_task),
            .key_prio   (key_prio),
            .left_task  (l_task),
            .left_prio  (l_prio),
            .left_valid (l_valid),
            .left_gt    (l_gt),
            .left_hole  (l_hole),
            .right_task (r_task),
            .right_prio (r_prio),
            .right_valid(r_valid),
            .cell_task  (task_q[i]),
            .cell_prio  (prio_q[i]),
            .cell_valid (valid_q[i]),
            .cell_hole  (hole_q[i]),
            .cell_gt    (gt_q[i]),
            .cell_match (match_q[i]),
            .cell_same  (same_q[i])
        );
    end

    assign head_task       = task_q[0];
    assign flags.any_match = |match_q;
    assign flags.same_prio = |same_q;
    assign flags.hole_any  = |hole_q;

endmodule

// ----- rtl/priority_ready_queue.sv -----
// ----------------------------------------------------------------------------
// priority_ready_queue
// Scheduler ready queue: a chain of cells kept sorted by priority, with a
// small sequencer that runs insert, remove and change-priority operations.
// ----------------------------------------------------------------------------
// Each input beat is one operation and yields exactly one result beat. A
// rejected operation, a remove of an absent task, a change that leaves the
// task in place or an unused operation code goes from the lookup state
// straight to the result; an insert, or a change of an absent task, passes
// through the insert state first. A remove, or a change of a queued task,
// opens a gap at the task's cell that walks toward the tail one cell per
// cycle, so it takes longer the more queued tasks lie behind the removed
// one; a change then also passes through the insert state. The next beat
// is taken once the previous result is loaded into the output register.
module priority_ready_queue #(
    parameter int MAX_TASKS     = prq_pkg::DEF_MAX_TASKS,
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // func, task_id, priority_req, task_ready, running_task, running_valid
    input  logic [prq_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // status, head_task, head_valid, need_resched, queued_count
    output logic [prq_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import prq_pkg::*;

    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LOOK    = 3'd1;
    localparam logic [2:0] S_COMPACT = 3'd2;
    localparam logic [2:0] S_INSERT  = 3'd3;
    localparam logic [2:0] S_DONE    = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic [FUNC_W-1:0]        func_reg;
    logic [TASK_W-1:0]        task_reg;
    logic [PRIORITY_BITS-1:0] prio_reg;
    logic                     ready_reg;
    logic [TASK_W-1:0]        run_task_reg;
    logic                     run_valid_reg;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     ins_pending_reg, ins_pending_next;
    logic                     inserted_reg, inserted_next;
    logic                     nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic                     m_tvalid_reg;

    prq_ctrl_t         ctrl;
    prq_flags_t        flags;
    logic [TASK_W-1:0] head_task;
    logic              s_fire;
    logic              out_load;
    logic              head_valid;
    logic              need_resched;
    logic [TASK_W-1:0] head_out;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_load = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);

    prq_chain #(
        .MAX_TASKS    (MAX_TASKS),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .key_task (task_reg),
        .key_prio (prio_reg),
        .head_task(head_task),
        .flags    (flags)
    );

    always_comb begin
        state_next       = state_reg;
        status_next      = status_reg;
        ins_pending_next = ins_pending_reg;
        inserted_next    = inserted_reg;
        nonempty_next    = nonempty_reg;
        count_next       = count_reg;
        ctrl             = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    status_next      = STATUS_OK;
                    ins_pending_next = 1'b0;
                    inserted_next    = 1'b0;
                    nonempty_next    = 1'b0;
                    state_next       = S_LOOK;
                end
            end
            S_LOOK: begin
                case (func_reg)
                    FUNC_INSERT: begin
                        if (!ready_reg) begin
                            status_next = STATUS_NOT_READY;
                            state_next  = S_DONE;
                        end else if (flags.any_match) begin
                            status_next = STATUS_QUEUED;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_INSERT;
                        end
                    end
                    FUNC_REMOVE: begin
                        if (flags.any_match) begin
                            ctrl.load_hole = 1'b1;
                            count_next     = count_reg - CNT_W'(1);
                            state_next     = S_COMPACT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    FUNC_CHANGE: begin
                        if (!ready_reg) begin
                            status_next = STATUS_NOT_READY;
                            state_next  = S_DONE;
                        end else if (flags.same_prio) begin
                            state_next = S_DONE;
                        end else if (flags.any_match) begin
                            ctrl.load_hole   = 1'b1;
                            count_next       = count_reg - CNT_W'(1);
                            ins_pending_next = 1'b1;
                            state_next       = S_COMPACT;
                        end else begin
                            state_next = S_INSERT;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_COMPACT: begin
                ctrl.compact = 1'b1;
                if (!flags.hole_any) begin
                    state_next = ins_pending_reg ? S_INSERT : S_DONE;
                end
            end
            S_INSERT: begin
                // A full queue drops the task silently.
                if (count_reg != CNT_W'(MAX_TASKS)) begin
                    ctrl.insert   = 1'b1;
                    count_next    = count_reg + CNT_W'(1);
                    inserted_next = 1'b1;
                    nonempty_next = (count_reg != '0);
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign head_valid   = (count_reg != '0);
    assign head_out     = head_valid ? head_task : '0;
    assign need_resched = inserted_reg && nonempty_reg &&
                          (!run_valid_reg || (head_task != run_task_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            status_reg      <= STATUS_OK;
            ins_pending_reg <= 1'b0;
            inserted_reg    <= 1'b0;
            nonempty_reg    <= 1'b0;
            count_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            status_reg      <= status_next;
            ins_pending_reg <= ins_pending_next;
            inserted_reg    <= inserted_next;
            nonempty_reg    <= nonempty_next;
            count_reg       <= count_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Operands of the beat in progress.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            func_reg      <= s_tdata[1:0];
            task_reg      <= s_tdata[6:2];
            prio_reg      <= PRIORITY_BITS'(s_tdata[14:7]);
            ready_reg     <= s_tdata[15];
            run_task_reg  <= s_tdata[20:16];
            run_valid_reg <= s_tdata[21];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {1'b0, COUNT_W'(count_reg), need_resched, head_valid,
                            head_out, status_reg};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

// ----- bench/priority_ready_queue_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_ready_queue_tb
// Self-checking bench for the scheduler ready queue. A short table of
// operations covers the corner cases, then rounds of fill, churn, drain and
// noise traffic run with random gaps on both sides. Every result beat is
// compared with a typed-in table value or with a shadow queue in the bench.
// ----------------------------------------------------------------------------
module priority_ready_queue_tb;
    import prq_pkg::*;

    localparam int                DEPTH        = DEF_MAX_TASKS;
    localparam logic [FUNC_W-1:0] FUNC_SPARE   = 2'd3;
    localparam int                RANDOM_ITEMS = 520;
    localparam int                LONG_HOLD    = 300;
    localparam int                TAIL_CYCLES  = 80;
    localparam int                CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic                  run_valid;
        logic [TASK_W-1:0]     run_task;
        logic                  ready;
        logic [PRIO_REQ_W-1:0] prio;
        logic [TASK_W-1:0]     task_id;
        logic [FUNC_W-1:0]     func;
    } sched_op_t;

    // Listed from the highest bit down, matching the result beat layout.
    typedef struct packed {
        logic [COUNT_W-1:0]  queued_count;
        logic                need_resched;
        logic                head_valid;
        logic [TASK_W-1:0]   head_task;
        logic [STATUS_W-1:0] status;
    } sched_result_t;

    typedef struct packed {
        sched_op_t     op;
        logic          typed;
        sched_result_t want;
    } table_row_t;

    typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_NOISE} mix_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;

    // Shadow of the queue, kept packed from entry 0 in queue order.
    logic [TASK_W-1:0]     pq_task [DEPTH];
    logic [PRIO_REQ_W-1:0] pq_prio [DEPTH];
    int                    pq_len = 0;

    table_row_t    pending_rows[$];
    sched_result_t expected_reports[$];
    table_row_t    directed[$];

    int   errors       = 0;
    int   cycle_cnt    = 0;
    logic tx_quiet     = 1'b0;
    logic rx_quiet     = 1'b0;
    logic hold_off_req = 1'b0;

    priority_ready_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void dequeue_at(input int idx);
        int i;
        for (i = idx; i + 1 < pq_len; i++) begin
            pq_task[i] = pq_task[i + 1];
            pq_prio[i] = pq_prio[i + 1];
        end
        pq_len--;
    endfunction

    // Equal priorities keep arrival order: the new task goes behind them.
    function automatic logic enqueue_task(input logic [TASK_W-1:0] id,
                                          input logic [PRIO_REQ_W-1:0] prio);
        int pos;
        int i;
        if (pq_len >= DEPTH) return 1'b0;
        pos = pq_len;
        for (i = pq_len - 1; i >= 0; i--)
            if (pq_prio[i] > prio) pos = i;
        for (i = pq_len; i > pos; i--) begin
            pq_task[i] = pq_task[i - 1];
            pq_prio[i] = pq_prio[i - 1];
        end
        pq_task[pos] = id;
        pq_prio[pos] = prio;
        pq_len++;
        return 1'b1;
    endfunction

    function automatic sched_result_t ready_queue_step(input sched_op_t op);
        sched_result_t r;
        int            idx;
        int            i;
        logic          placed;
        logic          had_tasks;
        r         = '0;
        idx       = -1;
        placed    = 1'b0;
        had_tasks = 1'b0;
        for (i = 0; i < pq_len; i++)
            if (idx < 0 && pq_task[i] == op.task_id) idx = i;
        case (op.func)
            FUNC_INSERT: begin
                if (!op.ready) begin
                    r.status = STATUS_NOT_READY;
                end else if (idx >= 0) begin
                    r.status = STATUS_QUEUED;
                end else begin
                    had_tasks = (pq_len > 0);
                    placed    = enqueue_task(op.task_id, op.prio);
                end
            end
            FUNC_REMOVE: begin
                if (idx >= 0) dequeue_at(idx);
            end
            FUNC_CHANGE: begin
                if (!op.ready) begin
                    r.status = STATUS_NOT_READY;
                end else if (idx < 0 || pq_prio[idx] != op.prio) begin
                    if (idx >= 0) dequeue_at(idx);
                    had_tasks = (pq_len > 0);
                    placed    = enqueue_task(op.task_id, op.prio);
                end
            end
            default: begin
            end
        endcase
        r.head_valid   = (pq_len > 0);
        r.head_task    = (pq_len > 0) ? pq_task[0] : '0;
        r.queued_count = COUNT_W'(pq_len);
        r.need_resched = placed && had_tasks && (!op.run_valid || pq_task[0] != op.run_task);
        return r;
    endfunction

    function automatic sched_op_t mk_op(input logic [FUNC_W-1:0] func,
                                        input logic [TASK_W-1:0] id,
                                        input logic [PRIO_REQ_W-1:0] prio,
                                        input logic ready,
                                        input logic [TASK_W-1:0] run_task,
                                        input logic run_valid);
        sched_op_t op;
        op.func      = func;
        op.task_id   = id;
        op.prio      = prio;
        op.ready     = ready;
        op.run_task  = run_task;
        op.run_valid = run_valid;
        return op;
    endfunction

    function automatic sched_result_t mk_res(input logic [STATUS_W-1:0] status,
                                             input logic [TASK_W-1:0] head,
                                             input logic head_valid,
                                             input logic need_resched,
                                             input logic [COUNT_W-1:0] count);
        sched_result_t r;
        r.status       = status;
        r.head_task    = head;
        r.head_valid   = head_valid;
        r.need_resched = need_resched;
        r.queued_count = count;
        return r;
    endfunction

    // The shadow queue may lag the bus by one beat here; that only steers
    // the choice of ids, never the checking.
    function automatic sched_op_t draw_op(input mix_t kind, input logic [TASK_W-1:0] id);
        sched_op_t       op;
        logic [21:0]     raw;
        int              roll;
        int              len;
        int              j;
        len          = pq_len;
        op.task_id   = id;
        op.ready     = ($urandom_range(0, 9) != 0);
        op.run_valid = ($urandom_range(0, 3) != 0);
        op.run_task  = (len > 0 && $urandom_range(0, 9) < 4) ? pq_task[0]
                                                               : TASK_W'($urandom_range(0, 31));
        case ($urandom_range(0, 5))
            0:       op.prio = '0;
            1:       op.prio = '1;
            2, 3:    op.prio = PRIO_REQ_W'($urandom_range(0, 3));
            default: op.prio = PRIO_REQ_W'($urandom_range(0, 255));
        endcase
        roll = $urandom_range(0, 99);
        case (kind)
            MIX_FILL: begin
                op.func = (roll < 85) ? FUNC_INSERT : (roll < 95) ? FUNC_CHANGE : FUNC_REMOVE;
            end
            MIX_CHURN: begin
                op.func = (roll < 35) ? FUNC_INSERT : (roll < 70) ? FUNC_CHANGE : FUNC_REMOVE;
                if (len > 0 && $urandom_range(0, 1) == 1) begin
                    j          = $urandom_range(0, len - 1);
                    op.task_id = pq_task[j];
                    if ($urandom_range(0, 9) < 3) op.prio = pq_prio[j];
                end
            end
            MIX_DRAIN: begin
                op.func = (roll < 85) ? FUNC_REMOVE : (roll < 95) ? FUNC_CHANGE : FUNC_INSERT;
            end
            default: begin
                raw = 22'($urandom);
                op  = raw;
            end
        endcase
        return op;
    endfunction

    task automatic offer_op(input table_row_t row);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        pending_rows.push_back(row);
        s_tdata  <= S_TDATA_W'(row.op);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_rows.size() != 0 || expected_reports.size() != 0) @(posedge aclk);
    endtask

    // Input side: predict on every accepted beat, or take the typed-in value.
    always @(posedge aclk) begin
        table_row_t    row;
        sched_result_t predicted;
        if (aresetn && s_tvalid && s_tready) begin
            predicted = ready_queue_step(sched_op_t'(s_tdata[21:0]));
            row       = pending_rows.pop_front();
            expected_reports.push_back(row.typed ? row.want : predicted);
        end
    end

    // Result side.
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sched_result_t'(m_tdata[14:0]);
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: result beat %h arrived with nothing expected", $time, m_tdata);
            end else begin
                want = expected_reports.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                end
                if (got.head_task !== want.head_task) begin
                    errors++;
                    $display("%0t: head_task expected %0d got %0d", $time, want.head_task,
                             got.head_task);
                end
                if (got.head_valid !== want.head_valid) begin
                    errors++;
                    $display("%0t: head_valid expected %0d got %0d", $time, want.head_valid,
                             got.head_valid);
                end
                if (got.need_resched !== want.need_resched) begin
                    errors++;
                    $display("%0t: need_resched expected %0d got %0d", $time,
                             want.need_resched, got.need_resched);
                end
                if (got.queued_count !== want.queued_count) begin
                    errors++;
                    $display("%0t: queued_count expected %0d got %0d", $time,
                             want.queued_count, got.queued_count);
                end
            end
        end
    end

    // Receiver: a random stall before each beat, or one long hold on request.
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = hold_off_req ? LONG_HOLD : rx_quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
                hold_off_req = 1'b0;
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        sched_result_t none;
        table_row_t    row;
        int            perm [DEPTH];
        int            i;
        int            j;
        int            t;
        int            k;
        int            n;
        int            sent;
        int            round;
        mix_t          kind;

        none = '0;
        // Empty queue, rejections, equal-priority ordering, in-place change,
        // change of an absent task, removals at head, middle and tail.
        directed.push_back('{mk_op(FUNC_REMOVE, 5, 0, 1, 0, 0), 1'b1,
                             mk_res(STATUS_OK, 0, 0, 0, 0)});
        directed.push_back('{mk_op(FUNC_INSERT, 3, 10, 0, 0, 0), 1'b1,
                             mk_res(STATUS_NOT_READY, 0, 0, 0, 0)});
        directed.push_back('{mk_op(FUNC_CHANGE, 3, 10, 0, 0, 0), 1'b1,
                             mk_res(STATUS_NOT_READY, 0, 0, 0, 0)});
        directed.push_back('{mk_op(FUNC_INSERT, 0, 255, 1, 0, 0), 1'b1,
                             mk_res(STATUS_OK, 0, 1, 0, 1)});
        directed.push_back('{mk_op(FUNC_INSERT, 31, 0, 1, 0, 1), 1'b1,
                             mk_res(STATUS_OK, 31, 1, 1, 2)});
        directed.push_back('{mk_op(FUNC_INSERT, 31, 0, 1, 0, 1), 1'b1,
                             mk_res(STATUS_QUEUED, 31, 1, 0, 2)});
        directed.push_back('{mk_op(FUNC_INSERT, 7, 0, 1, 31, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_INSERT, 8, 128, 1, 31, 0), 1'b0, none});
        directed.push_back('{mk_op(FUNC_CHANGE, 7, 0, 1, 31, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_CHANGE, 0, 0, 1, 31, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_CHANGE, 20, 5, 1, 31, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_CHANGE, 31, 255, 1, 7, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_REMOVE, 8, 0, 1, 7, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_REMOVE, 9, 0, 1, 7, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_SPARE, 31, 255, 1, 31, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_INSERT, 4, 200, 0, 7, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_REMOVE, 7, 0, 1, 7, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_CHANGE, 20, 255, 1, 0, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_REMOVE, 31, 0, 1, 0, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_REMOVE, 0, 0, 1, 0, 1), 1'b0, none});
        directed.push_back('{mk_op(FUNC_REMOVE, 20, 0, 1, 0, 1), 1'b1,
                             mk_res(STATUS_OK, 0, 0, 0, 0)});
        directed.push_back('{mk_op(FUNC_CHANGE, 12, 17, 1, 3, 1), 1'b1,
                             mk_res(STATUS_OK, 12, 1, 0, 1)});
        directed.push_back('{mk_op(FUNC_REMOVE, 12, 17, 1, 3, 1), 1'b1,
                             mk_res(STATUS_OK, 0, 0, 0, 0)});

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) offer_op(directed[i]);
        s_tvalid <= 1'b0;
        wait_drained();

        // Each round fills the queue from a shuffled id list, churns it,
        // drains it and ends with unconstrained beats. The sender then
        // pauses until every result is back.
        sent  = 0;
        round = 0;
        while (sent < RANDOM_ITEMS) begin
            for (k = 0; k < 4; k++) begin
                kind     = mix_t'(k);
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
                if (round == 0 && kind == MIX_FILL) begin
                    tx_quiet     = 1'b1;
                    rx_quiet     = 1'b0;
                    hold_off_req = 1'b1;
                end
                for (i = 0; i < DEPTH; i++) perm[i] = i;
                for (i = DEPTH - 1; i > 0; i--) begin
                    j       = $urandom_range(0, i);
                    t       = perm[i];
                    perm[i] = perm[j];
                    perm[j] = t;
                end
                n = (kind == MIX_CHURN) ? 50 : (kind == MIX_NOISE) ? 20 : DEPTH;
                for (i = 0; i < n; i++) begin
                    row.op    = draw_op(kind, TASK_W'(perm[i % DEPTH]));
                    row.typed = 1'b0;
                    row.want  = none;
                    offer_op(row);
                end
                sent += n;
            end
            s_tvalid <= 1'b0;
            wait_drained();
            round++;
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
